// ----- hw/rtl/modular_exponent_unit_core_macros.svh -----
// Assertion helpers for the modular exponent core.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef MODULAR_EXPONENT_UNIT_CORE_MACROS_SVH
`define MODULAR_EXPONENT_UNIT_CORE_MACROS_SVH

// Implication checked in the same cycle.
`define MEXP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mexp_pkg.sv -----
package mexp_pkg;

    // Field widths
    localparam int RES_W  = 30;
    localparam int EXP_W  = 63;
    localparam int MUL_W  = RES_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int REM_W  = RES_W + 2;

    // Prime modulus and the Fermat inverse exponent
    localparam logic [RES_W-1:0] MOD_PRIME   = 30'd998244353;
    localparam logic [EXP_W-1:0] MOD_INV_EXP = EXP_W'(MOD_PRIME) - EXP_W'(2);

    // Barrett constant: floor(2^60 / prime), fits in 31 bits
    localparam logic [63:0]      BARRETT_MU_FULL = (64'd1 << 60) / 64'd998244353;
    localparam logic [MUL_W-1:0] BARRETT_MU      = BARRETT_MU_FULL[MUL_W-1:0];

    // Exponent sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_ACC,
        ST_SQR
    } mexp_state_t;

    // Modular multiplier phases
    typedef enum logic [2:0] {
        MM_IDLE,
        MM_QUOT,
        MM_QMOD,
        MM_SUB,
        MM_FIX
    } mexp_mm_phase_t;

endpackage

// ----- hw/rtl/modular_exponent_unit_core.sv -----
// A request runs one modular product per squaring and per set exponent bit; a square is
// skipped once no higher exponent bit is set. The slowest exponent is 2^63-1.
// Each modular product runs on the one shared 31x31 multiplier (Barrett reduction).
// A new request is taken only when idle; busy stays high until the result is strobed.
// done marks residue for exactly one cycle; the receiver cannot stall it.
// rst_n clears the sequencer asynchronously; no request is held over reset.
`include "modular_exponent_unit_core_macros.svh"

module modular_exponent_unit_core
    import mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             kind,
    input  logic [RES_W-1:0] base,
    input  logic [EXP_W-1:0] exponent,
    output logic             done,
    output logic [RES_W-1:0] residue
);

    mexp_state_t      state_reg;
    mexp_state_t      state_next;

    logic [RES_W-1:0] acc_reg;
    logic [RES_W-1:0] acc_next;
    logic [RES_W-1:0] sq_reg;
    logic [RES_W-1:0] sq_next;
    logic [EXP_W-1:0] exp_reg;
    logic [EXP_W-1:0] exp_next;
    logic [RES_W-1:0] residue_reg;
    logic [RES_W-1:0] residue_next;
    logic             done_reg;
    logic             done_next;

    logic             mm_start;
    logic [RES_W-1:0] mm_op_a;
    logic             mm_done;
    logic [RES_W-1:0] mm_product;
    logic [RES_W:0]   base_sub;
    logic [RES_W-1:0] base_red;

    // Bring a base at or above the prime back into range
    always_comb
    begin
        base_sub = {1'b0, base} - (RES_W + 1)'(MOD_PRIME);
        base_red = base_sub[RES_W] ? base : base_sub[RES_W-1:0];
    end

    mexp_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .op_a    (mm_op_a),
        .op_b    (sq_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    // Sequence square-and-multiply from the low exponent bit upward
    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        sq_next      = sq_reg;
        exp_next     = exp_reg;
        residue_next = residue_reg;
        done_next    = 1'b0;
        mm_start     = 1'b0;
        mm_op_a      = exp_reg[0] ? acc_reg : sq_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    acc_next   = RES_W'(1);
                    sq_next    = base_red;
                    exp_next   = kind ? MOD_INV_EXP : exponent;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (exp_reg == '0)
                begin
                    residue_next = acc_reg;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = exp_reg[0] ? ST_ACC : ST_SQR;
                end
            end
            ST_ACC:
            begin
                if (mm_done)
                begin
                    acc_next   = mm_product;
                    exp_next   = {exp_reg[EXP_W-1:1], 1'b0};
                    state_next = ST_STEP;
                end
            end
            ST_SQR:
            begin
                if (mm_done)
                begin
                    sq_next    = mm_product;
                    exp_next   = {1'b0, exp_reg[EXP_W-1:1]};
                    state_next = ST_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Hold the running power, accumulator, remaining exponent and result
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        sq_reg      <= sq_next;
        exp_reg     <= exp_next;
        residue_reg <= residue_next;
    end

    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign residue = residue_reg;

    `MEXP_ASSERT_NEXT(a_request_takes_busy, start && !busy, busy, "request accepted but core not busy")
    `MEXP_ASSERT_NOW(a_done_when_idle, done, !busy, "result strobed while still busy")
    `MEXP_ASSERT_NOW(a_residue_reduced, done, residue < MOD_PRIME, "result not reduced")
    `MEXP_ASSERT_NOW(a_power_reduced, busy && state_reg != ST_IDLE, sq_reg < MOD_PRIME, "power out of range")
    `MEXP_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")

endmodule

// ----- hw/rtl/mexp_modmul.sv -----
module mexp_modmul
    import mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RES_W-1:0] op_a,
    input  logic [RES_W-1:0] op_b,
    output logic             done,
    output logic [RES_W-1:0] product
);

    mexp_mm_phase_t phase_reg;
    mexp_mm_phase_t phase_next;

    logic [2*RES_W-1:0] prod_reg;
    logic [PROD_W-1:0]  qmu_reg;
    logic [REM_W-1:0]   qm_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [RES_W-1:0]   product_reg;
    logic               done_reg;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_out;
    logic [REM_W:0]     rem_sub1;
    logic [REM_W:0]     rem_sub2;
    logic [RES_W-1:0]   rem_fixed;

    // Steer the one shared multiplier by phase
    always_comb
    begin
        case (phase_reg)
            MM_IDLE:
            begin
                mul_a = {1'b0, op_a};
                mul_b = {1'b0, op_b};
            end
            MM_QUOT:
            begin
                mul_a = prod_reg[2*RES_W-1:RES_W-1];
                mul_b = BARRETT_MU;
            end
            MM_QMOD:
            begin
                mul_a = qmu_reg[PROD_W-1:MUL_W];
                mul_b = {1'b0, MOD_PRIME};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_out = mul_a * mul_b;

    // Fold the Barrett remainder, which stays below three times the prime
    always_comb
    begin
        rem_sub1 = {1'b0, rem_reg} - (REM_W + 1)'(MOD_PRIME);
        rem_sub2 = {1'b0, rem_reg} - (REM_W + 1)'({MOD_PRIME, 1'b0});
        if (!rem_sub2[REM_W])
            rem_fixed = rem_sub2[RES_W-1:0];
        else if (!rem_sub1[REM_W])
            rem_fixed = rem_sub1[RES_W-1:0];
        else
            rem_fixed = rem_reg[RES_W-1:0];
    end

    // Advance through multiply, quotient estimate, quotient times prime, subtract, fold
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            MM_IDLE: if (start) phase_next = MM_QUOT;
            MM_QUOT: phase_next = MM_QMOD;
            MM_QMOD: phase_next = MM_SUB;
            MM_SUB:  phase_next = MM_FIX;
            MM_FIX:  phase_next = MM_IDLE;
            default: phase_next = MM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MM_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == MM_FIX);
        end
    end

    // Hold the intermediate values of the reduction
    always_ff @(posedge clk)
    begin
        if (phase_reg == MM_IDLE && start)
            prod_reg <= mul_out[2*RES_W-1:0];
        if (phase_reg == MM_QUOT)
            qmu_reg <= mul_out;
        if (phase_reg == MM_QMOD)
            qm_reg <= mul_out[REM_W-1:0];
        if (phase_reg == MM_SUB)
            rem_reg <= prod_reg[REM_W-1:0] - qm_reg;
        if (phase_reg == MM_FIX)
            product_reg <= rem_fixed;
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    // Request kinds
    localparam logic KIND_POW = 1'b0;
    localparam logic KIND_INV = 1'b1;

    // Bound on the worst case from start to done
    localparam int MAX_LATENCY = 760;
    localparam int DRAIN_LIMIT = 4 * MAX_LATENCY;

    // Largest value that fits the base field
    localparam logic [RES_W-1:0] BASE_TOP = '1;

    typedef struct {
        logic             kind;
        logic [RES_W-1:0] base;
        logic [EXP_W-1:0] exponent;
        logic [RES_W-1:0] residue;
    } power_req_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             start    = 1'b0;
    logic             kind     = KIND_POW;
    logic [RES_W-1:0] base     = '0;
    logic [EXP_W-1:0] exponent = '0;
    logic             busy;
    logic             done;
    logic [RES_W-1:0] residue;

    power_req_t pending_residues[$];
    int         mismatch_count = 0;
    bit         steady_sender  = 1'b0;

    modular_exponent_unit_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .base     (base),
        .exponent (exponent),
        .done     (done),
        .residue  (residue)
    );

    always #5 clk = ~clk;

    // Right-to-left square-and-multiply, one exponent bit per pass
    function automatic logic [RES_W-1:0] mod_power(input logic [RES_W-1:0] b,
                                                   input logic [EXP_W-1:0] e);
        longint unsigned prime;
        longint unsigned acc;
        longint unsigned sq;
        prime = 64'(MOD_PRIME);
        acc   = 1;
        sq    = 64'(b) % prime;
        for (int i = 0; i < EXP_W; i++)
        begin
            if (e[i])
                acc = (acc * sq) % prime;
            sq = (sq * sq) % prime;
        end
        return RES_W'(acc);
    endfunction

    // Hold the request until the core takes it, then log the expected residue
    task automatic send_request(input logic k, input logic [RES_W-1:0] b,
                                input logic [EXP_W-1:0] e);
        power_req_t req;
        start    <= 1'b1;
        kind     <= k;
        base     <= b;
        exponent <= e;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        req.kind     = k;
        req.base     = b;
        req.exponent = e;
        req.residue  = mod_power(b, (k == KIND_INV) ? MOD_INV_EXP : e);
        pending_residues.push_back(req);
    endtask

    // Drop start for a random gap now and then, mostly short, sometimes long
    task automatic sender_gap();
        int gap;
        if (!steady_sender && $urandom_range(99) < 26)
        begin
            if ($urandom_range(9) == 0)
                gap = $urandom_range(1, MAX_LATENCY);
            else
                gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait for every outstanding residue, with a bound
    task automatic wait_for_results();
        int waited;
        waited = 0;
        while (pending_residues.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    function automatic logic [RES_W-1:0] random_base();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(2))
                    0:       return '0;
                    1:       return RES_W'(1);
                    default: return MOD_PRIME - RES_W'(1);
                endcase
            end
            // above the prime: must be reduced first
            1: return MOD_PRIME + RES_W'($urandom_range(0, BASE_TOP - MOD_PRIME));
            default: return RES_W'($urandom_range(0, MOD_PRIME - 1));
        endcase
    endfunction

    function automatic logic [EXP_W-1:0] random_exponent();
        logic [63:0]      raw;
        logic [EXP_W-1:0] mask;
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1: return raw[EXP_W-1:0];
            2:
            begin
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return EXP_W'(1);
                    2:       return '1;
                    default: return EXP_W'(MOD_PRIME) - EXP_W'(1);
                endcase
            end
            default:
            begin
                // keep most exponents short so the run stays quick
                mask = (EXP_W'(1) << $urandom_range(1, 16)) - EXP_W'(1);
                return raw[EXP_W-1:0] & mask;
            end
        endcase
    endfunction

    // Edge values of every field, both kinds, and the special cases
    task automatic test_directed();
        // zero exponent gives one, zero base included
        send_request(KIND_POW, '0, '0);
        send_request(KIND_POW, MOD_PRIME - RES_W'(1), '0);
        send_request(KIND_POW, BASE_TOP, '0);
        send_request(KIND_POW, '0, EXP_W'(1));
        send_request(KIND_POW, '0, '1);
        send_request(KIND_POW, RES_W'(1), '1);
        send_request(KIND_POW, MOD_PRIME - RES_W'(1), '1);
        send_request(KIND_POW, RES_W'(2), EXP_W'(62));
        send_request(KIND_POW, RES_W'(3), EXP_W'(1) << (EXP_W - 1));
        // Fermat: a^(p-1) is one for a non-zero residue
        send_request(KIND_POW, RES_W'(12345), EXP_W'(MOD_PRIME) - EXP_W'(1));
        // base above the prime is reduced first
        send_request(KIND_POW, MOD_PRIME, EXP_W'(5));
        send_request(KIND_POW, MOD_PRIME + RES_W'(1), '1);
        send_request(KIND_POW, BASE_TOP, EXP_W'(1));
        send_request(KIND_POW, BASE_TOP, '1);
        // inverse of zero is zero
        send_request(KIND_INV, '0, '0);
        send_request(KIND_INV, RES_W'(1), '0);
        send_request(KIND_INV, RES_W'(2), '0);
        send_request(KIND_INV, MOD_PRIME - RES_W'(1), '0);
        send_request(KIND_INV, MOD_PRIME, '1);
        send_request(KIND_INV, BASE_TOP, '0);
        // exponent is ignored in inverse mode
        send_request(KIND_INV, RES_W'(3), '1);
        send_request(KIND_INV, RES_W'(7), EXP_W'(1) << (EXP_W - 1));
    endtask

    // Random requests, a quarter of them inverses
    task automatic test_random(input int count);
        logic k;
        for (int n = 0; n < count; n++)
        begin
            sender_gap();
            k = ($urandom_range(3) == 0) ? KIND_INV : KIND_POW;
            send_request(k, random_base(), random_exponent());
        end
    endtask

    // Back-to-back requests with no gaps at all
    task automatic test_steady_stream(input int count);
        steady_sender = 1'b1;
        test_random(count);
        steady_sender = 1'b0;
    endtask

    // Hold off the sender until every residue is back, then carry on
    task automatic test_drain_pause();
        test_random(10);
        start <= 1'b0;
        wait_for_results();
        @(posedge clk);
    endtask

    // Compare each strobed residue with the oldest expectation
    always @(posedge clk)
    begin : residue_check
        power_req_t req;
        if (rst_n && done)
        begin
            if (pending_residues.size() == 0)
            begin
                $display("%0t: unexpected residue, expected none, actual %0d", $time, residue);
                mismatch_count++;
            end
            else
            begin
                req = pending_residues.pop_front();
                if (residue !== req.residue)
                begin
                    $display("%0t: kind %0d base %0d exponent %0d: expected %0d, actual %0d",
                             $time, req.kind, req.base, req.exponent, req.residue, residue);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(480);
        test_drain_pause();
        test_steady_stream(300);
        test_random(540);

        // Wait out the tail and catch any stray strobe
        start <= 1'b0;
        wait_for_results();
        repeat (MAX_LATENCY) @(posedge clk);
        if (pending_residues.size() != 0)
        begin
            $display("%0t: %0d residues never arrived", $time, pending_residues.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Bound the run well above the slowest correct one
    initial
    begin
        #100_000_000;
        $display("%0t: timeout", $time);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
